### hw/rtl/mofe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mofe_pkg
// Shared types, character codes and phase codes of the operator field
// extractor.
// ----------------------------------------------------------------------------
package mofe_pkg;

  // Input transaction: one byte of response text
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  // Output transaction: one byte of the extracted name
  typedef struct packed {
    logic       found;
    logic       from_numeric;
    logic [7:0] name_byte;
    logic       last_of_run;
  } name_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic scan;     // scan the accepted text byte
    logic fetch;    // read both stores at the read index
    logic advance;  // step the read index
    logic clear;    // return the scan state to reset
  } mofe_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;     // current result is the final one of the response
  } mofe_status_t;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;

  // Tag length in bytes
  localparam logic [2:0] TAG_LEN = 3'd6;

  // Quoted candidate phases
  localparam logic [1:0] QP_WAIT   = 2'd0;
  localparam logic [1:0] QP_INSIDE = 2'd1;
  localparam logic [1:0] QP_NAMED  = 2'd2;
  localparam logic [1:0] QP_EMPTY  = 2'd3;

  // Comma field candidate phases
  localparam logic [1:0] FP_WAIT    = 2'd0;
  localparam logic [1:0] FP_SKIP    = 2'd1;
  localparam logic [1:0] FP_COLLECT = 2'd2;
  localparam logic [1:0] FP_DONE    = 2'd3;

  // Tag character expected at a match position
  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = CH_PLUS;
      3'd1:    ch = CH_C;
      3'd2:    ch = CH_O;
      3'd3:    ch = CH_P;
      3'd4:    ch = CH_S;
      3'd5:    ch = CH_COLON;
      default: ch = CH_PLUS;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mofe_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mofe_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface mofe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hw/rtl/mofe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mofe_datapath
// Tag matcher, quoted and comma field trackers, candidate stores, read
// index and result formatting.
// ----------------------------------------------------------------------------
module mofe_datapath #(
  parameter int NAME_CAP = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mofe_pkg::mofe_cmd_t cmd,
  input  wire logic [7:0]          text_byte,
  output mofe_pkg::mofe_status_t   status,
  output mofe_pkg::name_item_t     result
);

  localparam int DEPTH = NAME_CAP - 1;
  localparam int LEN_W = $clog2(NAME_CAP);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

  // Scan state
  logic [2:0]       tag_pos, tag_pos_next;
  logic             tag_seen, tag_seen_next;
  logic             text_ended, text_ended_next;
  logic [1:0]       quote_phase, quote_phase_next;
  logic [LEN_W-1:0] quoted_len, quoted_len_next;
  logic [1:0]       comma_count, comma_count_next;
  logic [1:0]       field_phase, field_phase_next;
  logic [LEN_W-1:0] field_len, field_len_next;
  logic [LEN_W-1:0] rd_idx, rd_idx_next;

  // Candidate stores
  logic [7:0] quoted_store [DEPTH];
  logic [7:0] field_store  [DEPTH];
  logic [7:0] quoted_rd;
  logic [7:0] field_rd;
  logic       quoted_we;
  logic       field_we;

  logic is_end;
  logic is_blank;

  assign is_end   = (text_byte == mofe_pkg::CH_COMMA) || (text_byte == mofe_pkg::CH_CR) ||
                    (text_byte == mofe_pkg::CH_LF);
  assign is_blank = (text_byte == mofe_pkg::CH_SPACE) || (text_byte == mofe_pkg::CH_TAB);

  // Work out the scan state after one byte
  always_comb begin
    tag_pos_next     = tag_pos;
    tag_seen_next    = tag_seen;
    text_ended_next  = text_ended;
    quote_phase_next = quote_phase;
    quoted_len_next  = quoted_len;
    comma_count_next = comma_count;
    field_phase_next = field_phase;
    field_len_next   = field_len;
    quoted_we        = 1'b0;
    field_we         = 1'b0;

    if (cmd.clear) begin
      tag_pos_next     = 3'd0;
      tag_seen_next    = 1'b0;
      text_ended_next  = 1'b0;
      quote_phase_next = mofe_pkg::QP_WAIT;
      quoted_len_next  = '0;
      comma_count_next = 2'd0;
      field_phase_next = mofe_pkg::FP_WAIT;
      field_len_next   = '0;
    end else if (cmd.scan && !text_ended) begin
      if (text_byte == mofe_pkg::CH_NUL) begin
        text_ended_next = 1'b1;
      end else if (!tag_seen) begin
        // advance the tag match, restart on a mismatch
        if (text_byte == mofe_pkg::tag_char(tag_pos)) begin
          if (tag_pos + 3'd1 == mofe_pkg::TAG_LEN) begin
            tag_seen_next = 1'b1;
            tag_pos_next  = 3'd0;
          end else begin
            tag_pos_next = tag_pos + 3'd1;
          end
        end else begin
          tag_pos_next = (text_byte == mofe_pkg::CH_PLUS) ? 3'd1 : 3'd0;
        end
      end else begin
        // quoted candidate
        if (quote_phase == mofe_pkg::QP_WAIT) begin
          if (text_byte == mofe_pkg::CH_QUOTE) begin
            quote_phase_next = mofe_pkg::QP_INSIDE;
          end
        end else if (quote_phase == mofe_pkg::QP_INSIDE) begin
          if (text_byte == mofe_pkg::CH_QUOTE) begin
            quote_phase_next = (quoted_len != '0) ? mofe_pkg::QP_NAMED : mofe_pkg::QP_EMPTY;
          end else if (quoted_len < DEPTH_L) begin
            quoted_we       = 1'b1;
            quoted_len_next = quoted_len + LEN_W'(1);
          end
        end

        // comma field candidate
        if (field_phase == mofe_pkg::FP_WAIT) begin
          if (text_byte == mofe_pkg::CH_COMMA) begin
            if (comma_count == 2'd1) begin
              comma_count_next = 2'd2;
              field_phase_next = mofe_pkg::FP_SKIP;
            end else begin
              comma_count_next = comma_count + 2'd1;
            end
          end
        end else if (field_phase == mofe_pkg::FP_SKIP ||
                     field_phase == mofe_pkg::FP_COLLECT) begin
          if (is_end) begin
            field_phase_next = mofe_pkg::FP_DONE;
          end else if (!(field_phase == mofe_pkg::FP_SKIP && is_blank)) begin
            field_phase_next = mofe_pkg::FP_COLLECT;
            if (field_len < DEPTH_L) begin
              field_we       = 1'b1;
              field_len_next = field_len + LEN_W'(1);
            end
          end
        end
      end
    end
  end

  // Step the read index over the results
  always_comb begin
    rd_idx_next = rd_idx;
    if (cmd.clear) begin
      rd_idx_next = '0;
    end else if (cmd.advance) begin
      rd_idx_next = rd_idx + LEN_W'(1);
    end
  end

  // Hold the scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_pos     <= 3'd0;
      tag_seen    <= 1'b0;
      text_ended  <= 1'b0;
      quote_phase <= mofe_pkg::QP_WAIT;
      quoted_len  <= '0;
      comma_count <= 2'd0;
      field_phase <= mofe_pkg::FP_WAIT;
      field_len   <= '0;
      rd_idx      <= '0;
    end else begin
      tag_pos     <= tag_pos_next;
      tag_seen    <= tag_seen_next;
      text_ended  <= text_ended_next;
      quote_phase <= quote_phase_next;
      quoted_len  <= quoted_len_next;
      comma_count <= comma_count_next;
      field_phase <= field_phase_next;
      field_len   <= field_len_next;
      rd_idx      <= rd_idx_next;
    end
  end

  // Write the candidate stores
  always_ff @(posedge clk) begin
    if (quoted_we) begin
      quoted_store[quoted_len[IDX_W-1:0]] <= text_byte;
    end
    if (field_we) begin
      field_store[field_len[IDX_W-1:0]] <= text_byte;
    end
  end

  // Read both stores at the read index
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      quoted_rd <= quoted_store[rd_idx[IDX_W-1:0]];
      field_rd  <= field_store[rd_idx[IDX_W-1:0]];
    end
  end

  // Pick the candidate and format the result
  logic             sel_quoted;
  logic             sel_field;
  logic [LEN_W-1:0] run_len;
  logic [LEN_W:0]   idx_inc;

  assign sel_quoted = tag_seen && (quote_phase == mofe_pkg::QP_NAMED) && (quoted_len != '0);
  assign sel_field  = !sel_quoted && tag_seen && (field_phase[1] == 1'b1) && (field_len != '0);
  assign run_len    = sel_quoted ? quoted_len : field_len;
  assign idx_inc    = {1'b0, rd_idx} + {{LEN_W{1'b0}}, 1'b1};

  assign status.last = !(sel_quoted || sel_field) || (idx_inc == {1'b0, run_len});

  assign result.found        = sel_quoted || sel_field;
  assign result.from_numeric = sel_field;
  assign result.name_byte    = sel_quoted ? quoted_rd : (sel_field ? field_rd : mofe_pkg::CH_NUL);
  assign result.last_of_run  = status.last;

endmodule
`default_nettype wire

### hw/rtl/mofe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mofe_ctrl
// Controller: scans text bytes, then reads out the result bytes one by one.
// ----------------------------------------------------------------------------
module mofe_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   in_last,
  output logic                        in_ready,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  input  wire mofe_pkg::mofe_status_t status,
  output mofe_pkg::mofe_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_SCAN  = 3'b001,
    ST_FETCH = 3'b010,
    ST_SEND  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   in_xfer;
  logic   out_xfer;

  assign in_ready  = (state == ST_SCAN);
  assign out_valid = (state == ST_SEND);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // Issue datapath commands
  always_comb begin
    cmd.scan    = in_xfer;
    cmd.fetch   = (state == ST_FETCH);
    cmd.advance = out_xfer && !status.last;
    cmd.clear   = out_xfer && status.last;
  end

  // Sequence scan, read and send
  always_comb begin
    state_next = state;
    unique case (state)
      ST_SCAN: begin
        if (in_xfer && in_last) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_SEND;
      end
      ST_SEND: begin
        if (out_xfer) begin
          state_next = status.last ? ST_SCAN : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_SCAN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SCAN;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/modem_operator_field_extractor_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modem_operator_field_extractor_top
// Text byte without end mark: one byte per cycle while scanning.
// Final byte: the controller passes through a fetch state (store read) and then a send state
// for each result, up to NAME_CAP-1 results; no text is taken until the last result is sent.
// Reset clears the control state; the candidate stores are not cleared.
// ----------------------------------------------------------------------------
module modem_operator_field_extractor_top #(
  parameter int NAME_CAP = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  mofe_stream_if.sink   text_ch,
  mofe_stream_if.source name_ch
);

  mofe_pkg::mofe_cmd_t    cmd;
  mofe_pkg::mofe_status_t status;
  mofe_pkg::text_item_t   text_item;
  mofe_pkg::name_item_t   result;

  assign text_item       = text_ch.payload;
  assign name_ch.payload = result;

  // Controller
  mofe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text_ch.valid),
    .in_last   (text_item.end_of_text),
    .in_ready  (text_ch.ready),
    .out_valid (name_ch.valid),
    .out_ready (name_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath
  mofe_datapath #(
    .NAME_CAP (NAME_CAP)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .text_byte (text_item.text_byte),
    .status    (status),
    .result    (result)
  );

endmodule
`default_nettype wire
